>>> rtl/bvs_pkg.sv
// Shared command codes, status codes and sequencer states for the bounded vector store.
package bvs_pkg;

  typedef enum logic [3:0] {
    CMD_READ   = 4'd0,
    CMD_WRITE  = 4'd1,
    CMD_PUSH   = 4'd2,
    CMD_POP    = 4'd3,
    CMD_INSERT = 4'd4,
    CMD_ERASE  = 4'd5,
    CMD_RESIZE = 4'd6,
    CMD_ASSIGN = 4'd7,
    CMD_CLEAR  = 4'd8,
    CMD_FRONT  = 4'd9,
    CMD_BACK   = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_RD_WAIT = 7'b0000100,
    S_MOVE_RD = 7'b0001000,
    S_MOVE_WR = 7'b0010000,
    S_FILL    = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_e;

  localparam int unsigned FieldBits = 7;
  localparam int unsigned DataBits  = 32;

endpackage

>>> rtl/bvs_mem.sv
// Element memory with one write port and one registered read port.
module bvs_mem #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AW        = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bvs_step.sv
// Shared pointer step unit: one increment or decrement and one equality compare.
module bvs_step #(
  parameter int unsigned CW = 7
) (
  input  logic [CW-1:0] ptr_i,
  input  logic          up_i,
  input  logic          use_nxt_i,
  input  logic [CW-1:0] target_i,
  output logic [CW-1:0] nxt_o,
  output logic          hit_o
);

  logic [CW-1:0] nxt;

  always_comb begin
    nxt   = up_i ? (ptr_i + CW'(1)) : (ptr_i - CW'(1));
    nxt_o = nxt;
    hit_o = (use_nxt_i ? nxt : ptr_i) == target_i;
  end

endmodule

>>> rtl/bvs_ctrl.sv
// Command sequencer that decodes each command and walks the memory for shifts and fills.
module bvs_ctrl
  import bvs_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AW        = 6,
  parameter int unsigned CW        = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  command_i,
  input  logic [FieldBits-1:0]        index_i,
  input  logic signed [DataBits-1:0]  value_i,
  input  logic [FieldBits-1:0]        length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DataBits-1:0]  read_data_o,
  output logic [1:0]                  status_o,
  output logic [FieldBits-1:0]        count_now_o,
  output logic                        is_empty_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [WORD_BITS-1:0]        mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [WORD_BITS-1:0]        mem_rdata_i
);

  localparam int unsigned KW = (CW > FieldBits) ? CW : FieldBits;
  localparam int unsigned XW = (WORD_BITS > DataBits) ? WORD_BITS : DataBits;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [3:0]           cmd_q;
  logic [FieldBits-1:0] idx_q, len_q;
  logic [WORD_BITS-1:0] val_q;
  logic [DataBits-1:0]  rd_q, rd_d;
  status_e              st_q, st_d;

  logic [KW-1:0] cnt_k, idx_k, len_k, depth_k;
  logic [XW-1:0] val_ext, rd_ext;
  logic          in_xfer, is_ins, is_fill;
  logic          idx_lt, idx_le, full, len_big, empty;
  logic [CW-1:0] step_nxt, step_target;
  logic          step_hit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_RESP);

  assign val_ext = XW'($unsigned(value_i));
  assign rd_ext  = XW'(mem_rdata_i);

  assign cnt_k   = KW'(cnt_q);
  assign idx_k   = KW'(idx_q);
  assign len_k   = KW'(len_q);
  assign depth_k = KW'(DEPTH);
  assign idx_lt  = idx_k < cnt_k;
  assign idx_le  = idx_k <= cnt_k;
  assign full    = cnt_k == depth_k;
  assign len_big = len_k > depth_k;
  assign empty   = cnt_q == '0;
  assign is_ins  = cmd_q == CMD_INSERT;
  assign is_fill = state_q == S_FILL;

  assign step_target = is_fill ? len_k[CW-1:0] : (is_ins ? idx_k[CW-1:0] : cnt_q);

  bvs_step #(
    .CW(CW)
  ) u_step (
    .ptr_i    (ptr_q),
    .up_i     (is_fill || !is_ins),
    .use_nxt_i(!is_fill && !is_ins),
    .target_i (step_target),
    .nxt_o    (step_nxt),
    .hit_o    (step_hit)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rd_d        = rd_q;
    st_d        = st_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q[AW-1:0];
    mem_wdata_o = val_q;
    mem_raddr_o = step_nxt[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        rd_d    = '0;
        st_d    = ST_OK;
        state_d = S_RESP;
        case (cmd_e'(cmd_q))
          CMD_READ: begin
            if (!idx_lt) begin
              st_d = ST_RANGE;
            end else begin
              mem_raddr_o = idx_k[AW-1:0];
              state_d     = S_RD_WAIT;
            end
          end
          CMD_WRITE: begin
            if (!idx_lt) begin
              st_d = ST_RANGE;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = idx_k[AW-1:0];
            end
          end
          CMD_PUSH: begin
            if (full) begin
              st_d = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = cnt_q[AW-1:0];
              cnt_d       = cnt_q + CW'(1);
            end
          end
          CMD_POP: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          CMD_INSERT: begin
            if (!idx_le) begin
              st_d = ST_RANGE;
            end else if (full) begin
              st_d = ST_FULL;
            end else begin
              ptr_d   = cnt_q;
              state_d = S_MOVE_RD;
            end
          end
          CMD_ERASE: begin
            if (!idx_lt) begin
              st_d = ST_RANGE;
            end else begin
              ptr_d   = idx_k[CW-1:0];
              state_d = S_MOVE_RD;
            end
          end
          CMD_RESIZE: begin
            if (len_big) begin
              st_d = ST_FULL;
            end else if (len_k <= cnt_k) begin
              cnt_d = len_k[CW-1:0];
            end else begin
              ptr_d   = cnt_q;
              state_d = S_FILL;
            end
          end
          CMD_ASSIGN: begin
            if (len_big) begin
              st_d = ST_FULL;
            end else begin
              ptr_d   = '0;
              state_d = S_FILL;
            end
          end
          CMD_CLEAR: begin
            cnt_d = '0;
          end
          CMD_FRONT: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              mem_raddr_o = '0;
              state_d     = S_RD_WAIT;
            end
          end
          CMD_BACK: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              mem_raddr_o = cnt_q[AW-1:0] - AW'(1);
              state_d     = S_RD_WAIT;
            end
          end
          default: begin
            st_d = ST_OK;
          end
        endcase
      end
      S_RD_WAIT: begin
        rd_d    = rd_ext[DataBits-1:0];
        state_d = S_RESP;
      end
      S_MOVE_RD: begin
        if (step_hit) begin
          state_d = S_RESP;
          if (is_ins) begin
            mem_we_o = 1'b1;
            cnt_d    = cnt_q + CW'(1);
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end else begin
          state_d = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        ptr_d       = step_nxt;
        state_d     = S_MOVE_RD;
      end
      S_FILL: begin
        if (step_hit) begin
          cnt_d   = len_k[CW-1:0];
          state_d = S_RESP;
        end else begin
          mem_we_o = 1'b1;
          ptr_d    = step_nxt;
        end
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= command_i;
      idx_q <= index_i;
      len_q <= length_i;
      val_q <= val_ext[WORD_BITS-1:0];
    end
    ptr_q <= ptr_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
  end

  assign read_data_o = rd_q;
  assign status_o    = st_q;
  assign count_now_o = cnt_k[FieldBits-1:0];
  assign is_empty_o  = empty;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    KW'(cnt_q) <= depth_k)
    else $error("Element count exceeds capacity.");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (KW'(mem_waddr_o) < depth_k))
    else $error("Memory write outside capacity.");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_DECODE))
    else $error("Accepted transfer did not enter decode.");

  a_shift_ptr_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE_WR) |-> (ptr_q <= cnt_q))
    else $error("Shift pointer beyond element count.");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cnt_q)))
    else $error("Count changed while a result was pending.");

endmodule

>>> rtl/bounded_vector_store_core.sv
// Top level of the bounded vector store: sequencer plus element memory.
// Read, front and back wait on the registered memory read; write, push, pop, clear, shrinking
// resize and refused commands answer straight from decode; insert and erase shift the entries
// one read and one write at a time, and growing resize and assign fill entries one at a time.
// One command at a time; the next transfer is taken the cycle after the result transfer.
// Reset clears the element count and the sequencer; memory contents are left as they are.
module bounded_vector_store_core
  import bvs_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [3:0]                 command_i,
  input  logic [FieldBits-1:0]       index_i,
  input  logic signed [DataBits-1:0] value_i,
  input  logic [FieldBits-1:0]       length_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DataBits-1:0] read_data_o,
  output logic [1:0]                 status_o,
  output logic [FieldBits-1:0]       count_now_o,
  output logic                       is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  bvs_ctrl #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .length_i   (length_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .read_data_o(read_data_o),
    .status_o   (status_o),
    .count_now_o(count_now_o),
    .is_empty_o (is_empty_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  bvs_mem #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .AW       (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
